/* rtl/yjk_pixel_group_to_rgb_core_defines.svh */
// Assertion helpers; clk and arst_n must be in scope where these are used.
`ifndef YJK_PIXEL_GROUP_TO_RGB_CORE_DEFINES_SVH
`define YJK_PIXEL_GROUP_TO_RGB_CORE_DEFINES_SVH

// same-cycle implication
`define YJK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define YJK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/yjk2rgb_pkg.sv */
`default_nettype none
package yjk2rgb_pkg;

	localparam int unsigned PAL_ENTRIES_DEF = 16;
	localparam int unsigned PAL_IDX_W       = 4;
	localparam int unsigned PAL_DATA_W      = 9;   // RRRGGGBBB
	localparam int unsigned LUMA_W          = 5;
	localparam logic [4:0]  CHAN_MAX        = 5'd31;

	typedef enum logic [0:0] {
		OP_GROUP     = 1'b0,
		OP_PAL_WRITE = 1'b1
	} opcode_t;

	typedef struct packed {
		logic                  we;
		logic [PAL_IDX_W-1:0]  idx;
		logic [PAL_DATA_W-1:0] data;
	} pal_wr_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// 5-bit channel to 8 bits by bit replication
	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	// 3-bit palette channel to 8 bits
	function automatic logic [7:0] widen3(input logic [2:0] v);
		return {v, v, v[2:1]};
	endfunction

	// clamp a signed intermediate to 0..31
	function automatic logic [4:0] sat5(input logic signed [9:0] v);
		logic [4:0] r;
		if (v < 10'sd0) begin
			r = 5'd0;
		end else if (v > 10'sd31) begin
			r = CHAN_MAX;
		end else begin
			r = v[4:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/yjk2rgb_palette.sv */
`default_nettype none
module yjk2rgb_palette import yjk2rgb_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pal_wr_t               wr,
	input  wire logic [PAL_IDX_W-1:0]  rd_idx,
	output logic      [PAL_DATA_W-1:0] rd_data
);

	localparam int unsigned ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [PAL_IDX_W:0] ENTRIES_L = (PAL_IDX_W+1)'(PALETTE_ENTRIES);

	logic [PAL_DATA_W-1:0] entry_q [PALETTE_ENTRIES];

	logic wr_hit;
	logic rd_hit;

	assign wr_hit = wr.we && ({1'b0, wr.idx} < ENTRIES_L);
	assign rd_hit = {1'b0, rd_idx} < ENTRIES_L;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(PALETTE_ENTRIES); i++) begin
				entry_q[i] <= '0;
			end
		end else if (wr_hit) begin
			entry_q[wr.idx[ADDR_W-1:0]] <= wr.data;
		end
	end

	// out-of-range reads give black
	always_comb begin
		rd_data = '0;
		if (rd_hit) begin
			rd_data = entry_q[rd_idx[ADDR_W-1:0]];
		end
	end

endmodule
`default_nettype wire

/* rtl/yjk2rgb_pixel.sv */
`default_nettype none
module yjk2rgb_pixel import yjk2rgb_pkg::*; (
	input  wire logic              [LUMA_W-1:0]     luma,
	input  wire logic signed       [5:0]            k_val,
	input  wire logic signed       [5:0]            j_val,
	input  wire logic                               palette_mode,
	input  wire logic              [PAL_DATA_W-1:0] pal_entry,
	output rgb_t                                    rgb
);

	logic signed [9:0] y_x;
	logic signed [9:0] k_x;
	logic signed [9:0] j_x;
	logic signed [9:0] r_sum;
	logic signed [9:0] g_sum;
	logic signed [9:0] b_sum;
	logic signed [9:0] b_quo;

	assign y_x   = $signed({5'b0, luma});
	assign k_x   = 10'(k_val);
	assign j_x   = 10'(j_val);
	assign r_sum = y_x + j_x;
	assign g_sum = y_x + k_x;
	// 5Y - 2J - K + 2, then floor divide by 4
	assign b_sum = (y_x <<< 2) + y_x - (j_x <<< 1) - k_x + 10'sd2;
	assign b_quo = b_sum >>> 2;

	always_comb begin
		if (palette_mode && luma[0]) begin
			rgb.red   = widen3(pal_entry[8:6]);
			rgb.green = widen3(pal_entry[5:3]);
			rgb.blue  = widen3(pal_entry[2:0]);
		end else begin
			rgb.red   = widen5(sat5(r_sum));
			rgb.green = widen5(sat5(g_sum));
			rgb.blue  = widen5(sat5(b_quo));
		end
	end

endmodule
`default_nettype wire

/* rtl/yjk_pixel_group_to_rgb_core.sv */
// A group's pixels go from the group register to the output register, and then out.
// The result channel carries one pixel per cycle unless out_ready stalls it;
//   a palette write request gives no result.
// The next request is taken in the same cycle the group's last pixel leaves the group register.
// Reset (arst_n low, asynchronous): palette all black, palette_mode 0, no pixel pending.
`default_nettype none
`include "yjk_pixel_group_to_rgb_core_defines.svh"
module yjk_pixel_group_to_rgb_core import yjk2rgb_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// config
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data,
	// request channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       opcode,
	input  wire logic [7:0] byte_a,
	input  wire logic [7:0] byte_b,
	input  wire logic [7:0] byte_c,
	input  wire logic [7:0] byte_d,
	input  wire logic [3:0] palette_index,
	input  wire logic [7:0] entry_red_blue,
	input  wire logic [7:0] entry_green,
	// pixel channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] red,
	output logic      [7:0] green,
	output logic      [7:0] blue,
	output logic      [1:0] pixel_slot,
	output logic            last_pixel
);

	// ---------------------------------------------------------------
	// Config register
	// ---------------------------------------------------------------
	logic palette_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			palette_mode_q <= cfg_wr_data;
		end
	end

	// ---------------------------------------------------------------
	// Handshake control
	// Stage 1 holds the group's four bytes and walks a slot counter;
	// the output register takes one pixel per cycle from it unless out_ready stalls it.
	// ---------------------------------------------------------------
	logic       s1_valid;
	logic [1:0] s1_slot;
	logic [7:0] s1_byte [4];

	logic       out_valid_q;
	rgb_t       out_rgb_q;
	logic [1:0] out_slot_q;
	logic       out_last_q;

	logic out_adv;    // output register can load this cycle
	logic s1_fire;    // a pixel moves from stage 1 to the output register
	logic s1_done;    // ...and it is the group's last one
	logic in_acc;
	logic grp_acc;

	assign out_adv  = !out_valid_q || out_ready;
	assign s1_fire  = s1_valid && out_adv;
	assign s1_done  = s1_fire && (s1_slot == 2'd3);
	// palette writes share the slot so they stay ordered behind pending reads
	assign in_ready = !s1_valid || s1_done;
	assign in_acc   = in_valid && in_ready;
	assign grp_acc  = in_acc && (opcode == OP_GROUP);

	// ---------------------------------------------------------------
	// Stage 1: group register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s1_slot  <= 2'd0;
		end else if (grp_acc) begin
			s1_valid <= 1'b1;
			s1_slot  <= 2'd0;
		end else if (s1_done) begin
			s1_valid <= 1'b0;
			s1_slot  <= 2'd0;
		end else if (s1_fire) begin
			s1_slot  <= s1_slot + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_acc) begin
			s1_byte[0] <= byte_a;
			s1_byte[1] <= byte_b;
			s1_byte[2] <= byte_c;
			s1_byte[3] <= byte_d;
		end
	end

	// ---------------------------------------------------------------
	// Palette store; a write lands at acceptance, after any read of the
	// previous group's last pixel in that same cycle
	// ---------------------------------------------------------------
	pal_wr_t               pal_wr;
	logic [LUMA_W-1:0]     cur_luma;
	logic [PAL_DATA_W-1:0] pal_entry;

	assign pal_wr.we   = in_acc && (opcode == OP_PAL_WRITE);
	assign pal_wr.idx  = palette_index;
	assign pal_wr.data = {entry_red_blue[6:4], entry_green[2:0], entry_red_blue[2:0]};

	yjk2rgb_palette #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (pal_wr),
		.rd_idx  (cur_luma[LUMA_W-1:1]),
		.rd_data (pal_entry)
	);

	// ---------------------------------------------------------------
	// Pixel conversion for the current slot
	// K from bytes 0/1, J from bytes 2/3 (low 3 bits each, low byte first)
	// ---------------------------------------------------------------
	logic signed [5:0] k_val;
	logic signed [5:0] j_val;
	rgb_t              pix_rgb;

	assign k_val = $signed({s1_byte[1][2:0], s1_byte[0][2:0]});
	assign j_val = $signed({s1_byte[3][2:0], s1_byte[2][2:0]});

	always_comb begin
		case (s1_slot)
			2'd0:    cur_luma = s1_byte[0][7:3];
			2'd1:    cur_luma = s1_byte[1][7:3];
			2'd2:    cur_luma = s1_byte[2][7:3];
			default: cur_luma = s1_byte[3][7:3];
		endcase
	end

	yjk2rgb_pixel u_pixel (
		.luma         (cur_luma),
		.k_val        (k_val),
		.j_val        (j_val),
		.palette_mode (palette_mode_q),
		.pal_entry    (pal_entry),
		.rgb          (pix_rgb)
	);

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_rgb_q  <= pix_rgb;
			out_slot_q <= s1_slot;
			out_last_q <= (s1_slot == 2'd3);
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = out_rgb_q.red;
	assign green      = out_rgb_q.green;
	assign blue       = out_rgb_q.blue;
	assign pixel_slot = out_slot_q;
	assign last_pixel = out_last_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`YJK_ASSERT_NEXT(a_grp_load, grp_acc, s1_valid && (s1_slot == 2'd0), "group not loaded at slot 0")
	`YJK_ASSERT_NEXT(a_pal_no_pix, pal_wr.we && !s1_valid, !s1_valid, "palette write made a pixel group")
	`YJK_ASSERT_NOW(a_last_slot, out_valid_q && out_last_q, out_slot_q == 2'd3, "last flag off slot 3")
	`YJK_ASSERT_NEXT(a_slot_seq, out_valid_q && out_ready && (out_slot_q != 2'd3), out_valid_q && (out_slot_q == $past(out_slot_q) + 2'd1), "pixel slots out of sequence")

endmodule
`default_nettype wire
